// ----- src/rrps_pkg.sv -----
// Package for the round-robin process scheduler.
// Holds the sizes, codes, state type and process-table entry type.
// It has no dependencies; the scheduler top level imports it.
package rrps_pkg;

   localparam int MaxProcs = 16;
   localparam int SlotW    = $clog2(MaxProcs);
   localparam int CntW     = $clog2(MaxProcs + 1);
   localparam int MaxEvents = 4;
   localparam int EvW      = $clog2(MaxEvents + 1);

   localparam logic [7:0] QUANTUM_RESET = 8'd4;

   // Operation codes of a request beat.
   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Event codes of a response beat.
   localparam logic [2:0] EV_ADMITTED   = 3'd0;
   localparam logic [2:0] EV_DISPATCHED = 3'd1;
   localparam logic [2:0] EV_PREEMPTED  = 3'd2;
   localparam logic [2:0] EV_BLOCKED    = 3'd3;
   localparam logic [2:0] EV_FINISHED   = 3'd4;
   localparam logic [2:0] EV_IO_DONE    = 3'd5;
   localparam logic [2:0] EV_IDLE       = 3'd6;
   localparam logic [2:0] EV_REJECTED   = 3'd7;

   // Queue numbers.
   localparam int Q_PENDING = 0;
   localparam int Q_NEW     = 1;
   localparam int Q_READY   = 2;
   localparam int Q_IO      = 3;
   localparam int NumQ      = 4;

   typedef logic [SlotW-1:0] slot_type;

   typedef struct packed {
      logic [7:0]  pid;
      logic [15:0] arrival_time;
      logic [7:0]  burst;
      logic [8:0]  io_left;
      logic [7:0]  second_burst;
   } entry_type;

   typedef struct packed {
      logic [2:0]  code;
      logic [7:0]  pid;
      logic [15:0] time_stamp;
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PEND,
      ST_ADMIT,
      ST_DISP,
      ST_RUN,
      ST_IO,
      ST_SEND
   } state_type;

endpackage

// ----- src/rrps_if.sv -----
// Handshake interfaces for the request and response channels.
// Depends on nothing; the scheduler top level uses both.
interface rrps_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [7:0]  pid;
   logic [15:0] arrival_time;
   logic [7:0]  first_burst;
   logic [7:0]  io_time;
   logic [7:0]  second_burst;

   modport source (output valid, op, pid, arrival_time, first_burst, io_time,
                   second_burst, input ready);
   modport sink (input valid, op, pid, arrival_time, first_burst, io_time,
                 second_burst, output ready);
endinterface

interface rrps_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  event_pid;
   logic [15:0] event_time;
   logic        last;

   modport source (output valid, event_res, event_pid, event_time, last, input ready);
   modport sink (input valid, event_res, event_pid, event_time, last, output ready);
endinterface

// ----- src/round_robin_process_scheduler.sv -----
// Round-robin process scheduler, top level.
// Depends on rrps_pkg and the interfaces in rrps_if.sv.
//
// One CPU, round-robin with a programmable slice (csr_wdata, reset 4, 0 means
// 256). An arrive beat gives no response unless the table is full, in which
// case one rejected beat follows. A tick beat is worked by a sequencer around
// a single process-table port, one table access per cycle: a pending phase that
// moves each due arrival from pending to new, then the admit, dispatch, run and
// I/O service phases, and then a send phase for each response beat (one to
// four). The request side is not ready until the last response beat is taken.
module round_robin_process_scheduler
   import rrps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   rrps_req_if.sink     req_bus,
   rrps_rsp_if.source   rsp_bus,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata
);

   state_type state_ff, state_in;

   entry_type tbl_ff [MaxProcs];
   logic [MaxProcs-1:0] free_ff, free_in;

   slot_type             qmem_ff [NumQ][MaxProcs];
   slot_type             head_ff [NumQ];
   logic [CntW-1:0]      cnt_ff  [NumQ];
   logic [NumQ-1:0]      q_pop, q_push;
   slot_type             q_push_slot [NumQ];

   slot_type    running_ff, running_in;
   logic        busy_ff, busy_in;
   logic [7:0]  qleft_ff, qleft_in;
   logic [7:0]  quantum_ff;
   logic [15:0] tick_ff, tick_in;

   event_type        evbuf_ff [MaxEvents];
   logic [EvW-1:0]   nev_ff, nev_in;
   logic [EvW-1:0]   sidx_ff, sidx_in;
   logic             ev_we;
   event_type        ev_data;

   slot_type    tbl_addr;
   entry_type   tbl_rd, tbl_wdata;
   logic        tbl_we;

   logic        found;
   slot_type    found_slot;
   logic        req_acc, rsp_acc, send_last;
   logic        pend_due;

   // Lowest free table slot.
   always_comb begin
      found = 1'b0;
      found_slot = '0;
      for (int i = MaxProcs - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            found = 1'b1;
            found_slot = SlotW'(i);
         end
      end
   end

   assign req_acc = req_bus.valid && req_bus.ready;
   assign rsp_acc = rsp_bus.valid && rsp_bus.ready;

   // Single table port: the address follows the phase.
   always_comb begin
      case (state_ff)
         ST_IDLE:  tbl_addr = found_slot;
         ST_PEND:  tbl_addr = qmem_ff[Q_PENDING][head_ff[Q_PENDING]];
         ST_ADMIT: tbl_addr = qmem_ff[Q_NEW][head_ff[Q_NEW]];
         ST_DISP:  tbl_addr = qmem_ff[Q_READY][head_ff[Q_READY]];
         ST_RUN:   tbl_addr = running_ff;
         ST_IO:    tbl_addr = qmem_ff[Q_IO][head_ff[Q_IO]];
         default:  tbl_addr = '0;
      endcase
   end
   assign tbl_rd = tbl_ff[tbl_addr];

   assign pend_due = (cnt_ff[Q_PENDING] != '0) && (tbl_rd.arrival_time <= tick_ff);
   assign send_last = (nev_ff == '0) || (sidx_ff == nev_ff - EvW'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_bus.op == OP_TICK) state_in = ST_PEND;
               else if (!found)           state_in = ST_SEND;
            end
         end
         ST_PEND:  if (!pend_due) state_in = ST_ADMIT;
         ST_ADMIT: state_in = ST_DISP;
         ST_DISP:  state_in = ST_RUN;
         ST_RUN:   state_in = ST_IO;
         ST_IO:    state_in = ST_SEND;
         ST_SEND:  if (rsp_acc && send_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath control for each phase.
   always_comb begin
      entry_type  e;
      logic [7:0] q1;
      logic [7:0] b;
      logic [8:0] io1;
      logic       leave;

      e = tbl_rd;
      q1 = qleft_ff - 8'd1;
      b = (tbl_rd.burst != '0) ? tbl_rd.burst - 8'd1 : 8'd0;
      io1 = (tbl_rd.io_left != '0) ? tbl_rd.io_left - 9'd1 : 9'd0;
      leave = 1'b0;

      free_in = free_ff;
      q_pop = '0;
      q_push = '0;
      for (int f = 0; f < NumQ; f++) q_push_slot[f] = tbl_addr;
      running_in = running_ff;
      busy_in = busy_ff;
      qleft_in = qleft_ff;
      tick_in = tick_ff;
      nev_in = nev_ff;
      sidx_in = sidx_ff;
      ev_we = 1'b0;
      ev_data = '{code: EV_IDLE, pid: tbl_rd.pid, time_stamp: tick_ff};
      tbl_we = 1'b0;
      tbl_wdata = tbl_rd;

      case (state_ff)
         ST_IDLE: begin
            nev_in = '0;
            sidx_in = '0;
            if (req_acc) begin
               if (req_bus.op == OP_TICK) begin
                  if (qleft_ff == '0) qleft_in = quantum_ff;
               end else if (found) begin
                  free_in[found_slot] = 1'b0;
                  tbl_we = 1'b1;
                  tbl_wdata = '{pid: req_bus.pid, arrival_time: req_bus.arrival_time,
                                burst: req_bus.first_burst,
                                io_left: {1'b0, req_bus.io_time},
                                second_burst: req_bus.second_burst};
                  q_push[Q_PENDING] = 1'b1;
                  q_push_slot[Q_PENDING] = found_slot;
               end else begin
                  ev_we = 1'b1;
                  ev_data = '{code: EV_REJECTED, pid: req_bus.pid, time_stamp: tick_ff};
                  nev_in = EvW'(1);
               end
            end
         end
         ST_PEND: begin
            if (pend_due) begin
               q_pop[Q_PENDING] = 1'b1;
               q_push[Q_NEW] = 1'b1;
            end
         end
         ST_ADMIT: begin
            if (cnt_ff[Q_NEW] != '0) begin
               q_pop[Q_NEW] = 1'b1;
               q_push[Q_READY] = 1'b1;
               ev_we = 1'b1;
               ev_data.code = EV_ADMITTED;
            end
         end
         ST_DISP: begin
            if (!busy_ff && cnt_ff[Q_READY] != '0) begin
               q_pop[Q_READY] = 1'b1;
               running_in = tbl_addr;
               busy_in = 1'b1;
               ev_we = 1'b1;
               ev_data.code = EV_DISPATCHED;
            end
         end
         ST_RUN: begin
            if (busy_ff) begin
               qleft_in = q1;
               e.burst = b;
               tbl_we = 1'b1;
               if (q1 == '0) begin
                  if (b == '0) begin
                     leave = 1'b1;
                  end else begin
                     busy_in = 1'b0;
                     q_push[Q_READY] = 1'b1;
                     ev_we = 1'b1;
                     ev_data.code = EV_PREEMPTED;
                  end
               end else if (b == '0) begin
                  qleft_in = quantum_ff;
                  leave = 1'b1;
               end
               // Burst done: block for I/O or finish.
               if (leave) begin
                  busy_in = 1'b0;
                  ev_we = 1'b1;
                  if (e.io_left != '0) begin
                     e.io_left = e.io_left + 9'd1;
                     e.burst = e.second_burst;
                     e.second_burst = '0;
                     q_push[Q_IO] = 1'b1;
                     ev_data.code = EV_BLOCKED;
                  end else begin
                     free_in[tbl_addr] = 1'b1;
                     ev_data.code = EV_FINISHED;
                  end
               end
               tbl_wdata = e;
            end
         end
         ST_IO: begin
            tick_in = tick_ff + 16'd1;
            if (cnt_ff[Q_IO] != '0) begin
               q_pop[Q_IO] = 1'b1;
               e.io_left = io1;
               tbl_we = 1'b1;
               tbl_wdata = e;
               if (io1 != '0) begin
                  q_push[Q_IO] = 1'b1;
               end else if (tbl_rd.burst != '0) begin
                  q_push[Q_READY] = 1'b1;
                  ev_we = 1'b1;
                  ev_data.code = EV_IO_DONE;
               end else begin
                  free_in[tbl_addr] = 1'b1;
                  ev_we = 1'b1;
                  ev_data.code = EV_FINISHED;
               end
            end
         end
         ST_SEND: begin
            if (rsp_acc) sidx_in = sidx_ff + EvW'(1);
         end
         default: ;
      endcase

      if (ev_we && state_ff != ST_IDLE) nev_in = nev_ff + EvW'(1);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         free_ff    <= '1;
         running_ff <= '0;
         busy_ff    <= 1'b0;
         qleft_ff   <= '0;
         quantum_ff <= QUANTUM_RESET;
         tick_ff    <= '0;
         nev_ff     <= '0;
         sidx_ff    <= '0;
         for (int f = 0; f < NumQ; f++) begin
            head_ff[f] <= '0;
            cnt_ff[f]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         free_ff    <= free_in;
         running_ff <= running_in;
         busy_ff    <= busy_in;
         qleft_ff   <= qleft_in;
         tick_ff    <= tick_in;
         nev_ff     <= nev_in;
         sidx_ff    <= sidx_in;
         if (csr_we) quantum_ff <= csr_wdata;
         for (int f = 0; f < NumQ; f++) begin
            if (q_pop[f]) head_ff[f] <= head_ff[f] + SlotW'(1);
            cnt_ff[f] <= cnt_ff[f] - CntW'(q_pop[f]) + CntW'(q_push[f]);
         end
      end
   end

   // Queue storage, process table and event buffer.
   always_ff @(posedge clock) begin
      for (int f = 0; f < NumQ; f++) begin
         if (q_push[f]) qmem_ff[f][head_ff[f] + cnt_ff[f][SlotW-1:0]] <= q_push_slot[f];
      end
      if (tbl_we) tbl_ff[tbl_addr] <= tbl_wdata;
      if (ev_we) begin
         if (state_ff == ST_IDLE) evbuf_ff[0] <= ev_data;
         else evbuf_ff[nev_ff[EvW-2:0]] <= ev_data;
      end
   end

   // Response beats.
   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = (state_ff == ST_SEND);
   assign rsp_bus.event_res  = (nev_ff == '0) ? EV_IDLE : evbuf_ff[sidx_ff[EvW-2:0]].code;
   assign rsp_bus.event_pid  = (nev_ff == '0) ? 8'd0 : evbuf_ff[sidx_ff[EvW-2:0]].pid;
   assign rsp_bus.event_time = (nev_ff == '0) ? tick_ff - 16'd1
                                              : evbuf_ff[sidx_ff[EvW-2:0]].time_stamp;
   assign rsp_bus.last       = send_last;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[Q_READY] <= CntW'(MaxProcs) && cnt_ff[Q_IO] <= CntW'(MaxProcs))
      else $error("queue count above table size");
   a_nev_bound: assert property (@(posedge clock) disable iff (reset)
      nev_ff <= EvW'(MaxEvents))
      else $error("too many events for one beat");
   a_busy_owned: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !free_ff[running_ff])
      else $error("running slot is marked free");
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_bus.op == OP_TICK |=> state_ff == ST_PEND)
      else $error("tick did not start the sequencer");
`endif

endmodule
